/* design/box_with_most_points_select_core_defines.svh */
// ---------------------------------------------------------------------------
// Box with most points select - assertion macros
// Shared assertion helpers for the select core. Clock i_clk, reset i_rst_n.
// ---------------------------------------------------------------------------
`ifndef BOX_WITH_MOST_POINTS_SELECT_CORE_DEFINES_SVH
`define BOX_WITH_MOST_POINTS_SELECT_CORE_DEFINES_SVH

// same-cycle implication
`define BWMP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BWMP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* design/bwmp_pkg.sv */
// ---------------------------------------------------------------------------
// Box with most points select - package
// Field widths, box bound bundle and sequencer states.
// ---------------------------------------------------------------------------
package bwmp_pkg;

    localparam int COORD_W   = 16;
    localparam int EDGE_W    = 12;
    localparam int FRAC_W    = 4;
    localparam int BOX_OUT_W = 6;
    localparam int CNT_OUT_W = 8;

    localparam logic CMD_POINT = 1'b0;
    localparam logic CMD_BOX   = 1'b1;

    typedef struct packed {
        logic [COORD_W-1:0] lo_x;
        logic [COORD_W:0]   hi_x;
        logic [COORD_W-1:0] lo_y;
        logic [COORD_W:0]   hi_y;
    } t_bounds;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_LAST = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

endpackage

/* design/bwmp_ram.sv */
// ---------------------------------------------------------------------------
// Box with most points select - generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module bwmp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/bwmp_cmp.sv */
// ---------------------------------------------------------------------------
// Box with most points select - inside test
// Strict containment compare of one stored point against the box bounds.
// ---------------------------------------------------------------------------
module bwmp_cmp (
    input  logic [bwmp_pkg::COORD_W-1:0] i_px,
    input  logic [bwmp_pkg::COORD_W-1:0] i_py,
    input  bwmp_pkg::t_bounds            i_bounds,
    output logic                         o_hit
);

    logic in_x;
    logic in_y;

    assign in_x  = (i_bounds.lo_x < i_px) && ({1'b0, i_px} < i_bounds.hi_x);
    assign in_y  = (i_bounds.lo_y < i_py) && ({1'b0, i_py} < i_bounds.hi_y);
    assign o_hit = in_x && in_y;

endmodule

/* design/box_with_most_points_select_core.sv */
// ---------------------------------------------------------------------------
// Box with most points select - core
// Stores landmark points, counts points strictly inside each candidate box
// and reports the box with the most points at the end of a box run.
//
// Channel   Direction  Handshake        Payload
// command   in         start / busy     i_cmd .. i_last_box
// result    out        o_done strobe    o_best_box, o_best_count, o_overflow
//
// A point transfer is stored in the cycle it is taken; busy stays low.
// A box transfer scans the point store through one RAM read port and one
// compare unit, one point per cycle, with busy high until the box finishes.
// A box beyond the run capacity is not scanned; busy stays low.
// The result strobe is registered: it comes in the cycle after the last box finishes.
// Reset clears the point count, the run and the sticky drop flag behind
// o_overflow (not o_overflow itself); no clearing pass. The receiver cannot stall the result.
// ---------------------------------------------------------------------------
`include "box_with_most_points_select_core_defines.svh"

module box_with_most_points_select_core #(
    parameter int MAX_POINTS = 128,
    parameter int MAX_BOXES  = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_cmd,
    input  logic                                 i_first_point,
    input  logic [bwmp_pkg::COORD_W-1:0]         i_point_x,
    input  logic [bwmp_pkg::COORD_W-1:0]         i_point_y,
    input  logic [bwmp_pkg::EDGE_W-1:0]          i_box_left,
    input  logic [bwmp_pkg::EDGE_W-1:0]          i_box_top,
    input  logic [bwmp_pkg::EDGE_W-1:0]          i_box_width,
    input  logic [bwmp_pkg::EDGE_W-1:0]          i_box_height,
    input  logic                                 i_last_box,
    output logic                                 o_done,
    output logic [bwmp_pkg::BOX_OUT_W-1:0]       o_best_box,
    output logic [bwmp_pkg::CNT_OUT_W-1:0]       o_best_count,
    output logic                                 o_overflow
);

    localparam int COORD_W   = bwmp_pkg::COORD_W;
    localparam int EDGE_W    = bwmp_pkg::EDGE_W;
    localparam int FRAC_W    = bwmp_pkg::FRAC_W;
    localparam int BOX_OUT_W = bwmp_pkg::BOX_OUT_W;
    localparam int CNT_OUT_W = bwmp_pkg::CNT_OUT_W;
    localparam int AW        = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW        = $clog2(MAX_POINTS + 1);
    localparam int BW        = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int PW        = $clog2(MAX_BOXES + 1);

    bwmp_pkg::t_state  r_state, n_state;
    bwmp_pkg::t_bounds r_bounds, n_bounds;

    logic [CW-1:0] r_total, n_total;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_hits, n_hits;
    logic          r_pend, n_pend;
    logic [PW-1:0] r_pos, n_pos;
    logic [BW-1:0] r_lead_idx, n_lead_idx;
    logic [CW-1:0] r_lead_cnt, n_lead_cnt;
    logic          r_dropped, n_dropped;
    logic          r_last, n_last;

    logic                 r_done, n_done;
    logic [BW-1:0]        r_best_box, n_best_box;
    logic [CW-1:0]        r_best_cnt, n_best_cnt;
    logic                 r_ovf, n_ovf;

    logic                 accept;
    logic                 we;
    logic [AW-1:0]        waddr;
    logic [2*COORD_W-1:0] rdata;
    logic                 hit;
    logic [EDGE_W:0]      right;
    logic [EDGE_W:0]      bottom;
    logic                 take_lead;

    assign busy   = (r_state != bwmp_pkg::S_IDLE);
    assign accept = start && !busy;

    assign we     = accept && (i_cmd == bwmp_pkg::CMD_POINT) &&
                    (i_first_point || (r_total < CW'(MAX_POINTS)));
    assign waddr  = i_first_point ? '0 : r_total[AW-1:0];
    assign right  = {1'b0, i_box_left} + {1'b0, i_box_width};
    assign bottom = {1'b0, i_box_top} + {1'b0, i_box_height};

    bwmp_ram #(
        .WIDTH (2 * COORD_W),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata ({i_point_x, i_point_y}),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rdata)
    );

    bwmp_cmp u_cmp (
        .i_px     (rdata[2*COORD_W-1:COORD_W]),
        .i_py     (rdata[COORD_W-1:0]),
        .i_bounds (r_bounds),
        .o_hit    (hit)
    );

    assign take_lead = (r_pos == '0) || (r_hits > r_lead_cnt);

    always_comb begin
        n_state    = r_state;
        n_bounds   = r_bounds;
        n_total    = r_total;
        n_idx      = r_idx;
        n_hits     = r_hits;
        n_pend     = r_pend;
        n_pos      = r_pos;
        n_lead_idx = r_lead_idx;
        n_lead_cnt = r_lead_cnt;
        n_dropped  = r_dropped;
        n_last     = r_last;
        n_done     = 1'b0;
        n_best_box = r_best_box;
        n_best_cnt = r_best_cnt;
        n_ovf      = r_ovf;
        case (r_state)
            bwmp_pkg::S_IDLE: begin
                if (accept && (i_cmd == bwmp_pkg::CMD_POINT)) begin
                    if (i_first_point) begin
                        n_total = CW'(1);
                    end else if (r_total < CW'(MAX_POINTS)) begin
                        n_total = r_total + CW'(1);
                    end else begin
                        n_dropped = 1'b1;
                    end
                end else if (accept) begin
                    if (r_pos < PW'(MAX_BOXES)) begin
                        n_bounds.lo_x = {i_box_left, FRAC_W'(0)};
                        n_bounds.hi_x = {right, FRAC_W'(0)};
                        n_bounds.lo_y = {i_box_top, FRAC_W'(0)};
                        n_bounds.hi_y = {bottom, FRAC_W'(0)};
                        n_last  = i_last_box;
                        n_idx   = '0;
                        n_hits  = '0;
                        n_pend  = 1'b0;
                        n_state = bwmp_pkg::S_SCAN;
                    end else begin
                        n_dropped = 1'b1;
                        if (i_last_box) begin
                            n_done     = 1'b1;
                            n_best_box = r_lead_idx;
                            n_best_cnt = r_lead_cnt;
                            n_ovf      = 1'b1;
                            n_pos      = '0;
                            n_lead_idx = '0;
                            n_lead_cnt = '0;
                        end
                    end
                end
            end
            bwmp_pkg::S_SCAN: begin
                n_hits = r_hits + CW'(hit && r_pend);
                if (r_idx < r_total) begin
                    n_idx  = r_idx + CW'(1);
                    n_pend = 1'b1;
                end else begin
                    n_state = bwmp_pkg::S_LAST;
                end
            end
            bwmp_pkg::S_LAST: begin
                n_pend  = 1'b0;
                n_state = bwmp_pkg::S_DONE;
            end
            bwmp_pkg::S_DONE: begin
                n_state = bwmp_pkg::S_IDLE;
                if (take_lead) begin
                    n_lead_idx = r_pos[BW-1:0];
                    n_lead_cnt = r_hits;
                end
                n_pos = r_pos + PW'(1);
                if (r_last) begin
                    n_done     = 1'b1;
                    n_best_box = take_lead ? r_pos[BW-1:0] : r_lead_idx;
                    n_best_cnt = take_lead ? r_hits : r_lead_cnt;
                    n_ovf      = r_dropped;
                    n_pos      = '0;
                    n_lead_idx = '0;
                    n_lead_cnt = '0;
                end
            end
            default: begin
                n_state = bwmp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= bwmp_pkg::S_IDLE;
            r_total    <= '0;
            r_idx      <= '0;
            r_hits     <= '0;
            r_pend     <= 1'b0;
            r_pos      <= '0;
            r_lead_idx <= '0;
            r_lead_cnt <= '0;
            r_dropped  <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_total    <= n_total;
            r_idx      <= n_idx;
            r_hits     <= n_hits;
            r_pend     <= n_pend;
            r_pos      <= n_pos;
            r_lead_idx <= n_lead_idx;
            r_lead_cnt <= n_lead_cnt;
            r_dropped  <= n_dropped;
            r_done     <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bounds   <= n_bounds;
        r_last     <= n_last;
        r_best_box <= n_best_box;
        r_best_cnt <= n_best_cnt;
        r_ovf      <= n_ovf;
    end

    assign o_done       = r_done;
    assign o_best_box   = BOX_OUT_W'(r_best_box);
    assign o_best_count = CNT_OUT_W'(r_best_cnt);
    assign o_overflow   = r_ovf;

    `BWMP_ASSERT_NOW(a_hits_le_idx, 1'b1, r_hits <= r_idx,
        "hit count exceeds points read")
    `BWMP_ASSERT_NOW(a_idx_le_total, busy, r_idx <= r_total,
        "scan index beyond stored points")
    `BWMP_ASSERT_NOW(a_total_cap, 1'b1, r_total <= CW'(MAX_POINTS),
        "point count beyond capacity")
    `BWMP_ASSERT_NOW(a_done_idle, o_done, !busy,
        "result strobe while busy")
    `BWMP_ASSERT_NEXT(a_scan_end,
        (r_state == bwmp_pkg::S_SCAN) && (r_idx == r_total),
        r_state == bwmp_pkg::S_LAST,
        "scan did not end after last point")

endmodule

/* tb/tb.sv */
// ---------------------------------------------------------------------------
// Box with most points select - testbench
// Loads landmark point sets and streams candidate box runs into the core
// through the start/busy command port. A scoreboard class keeps its own copy
// of the point store and run state, predicts the winner of every run and
// checks each o_done result field by field. Directed corner cases come first,
// then random point loads, box runs and noise under several idle phases,
// ending with point-store and run-capacity overflow.
// ---------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POINT_CAP    = 128;
    localparam int RUN_CAP      = 64;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 200;

    typedef struct packed {
        logic                               cmd;
        logic                               first_point;
        logic [bwmp_pkg::COORD_W-1:0]       point_x;
        logic [bwmp_pkg::COORD_W-1:0]       point_y;
        logic [bwmp_pkg::EDGE_W-1:0]        box_left;
        logic [bwmp_pkg::EDGE_W-1:0]        box_top;
        logic [bwmp_pkg::EDGE_W-1:0]        box_width;
        logic [bwmp_pkg::EDGE_W-1:0]        box_height;
        logic                               last_box;
    } t_command;

    typedef struct packed {
        logic [bwmp_pkg::BOX_OUT_W-1:0] best_box;
        logic [bwmp_pkg::CNT_OUT_W-1:0] best_count;
        logic                           overflow;
    } t_winner;

    class t_box_winner_board;
        logic [bwmp_pkg::COORD_W-1:0] xs [POINT_CAP];
        logic [bwmp_pkg::COORD_W-1:0] ys [POINT_CAP];
        int unsigned                  n_points;
        int unsigned                  run_pos;
        int unsigned                  lead_index;
        int unsigned                  lead_count;
        bit                           dropped;
        t_winner                      winners_due [$];
        int unsigned                  failures;

        function int unsigned count_points_inside(t_command c);
            logic [bwmp_pkg::COORD_W:0] lo_x, hi_x, lo_y, hi_y, px, py;
            int unsigned                hits;
            lo_x = {1'b0, c.box_left, {bwmp_pkg::FRAC_W{1'b0}}};
            lo_y = {1'b0, c.box_top, {bwmp_pkg::FRAC_W{1'b0}}};
            hi_x = {({1'b0, c.box_left} + {1'b0, c.box_width}),
                    {bwmp_pkg::FRAC_W{1'b0}}};
            hi_y = {({1'b0, c.box_top} + {1'b0, c.box_height}),
                    {bwmp_pkg::FRAC_W{1'b0}}};
            hits = 0;
            for (int i = 0; i < n_points; i++) begin
                px = {1'b0, xs[i]};
                py = {1'b0, ys[i]};
                if (lo_x < px && px < hi_x && lo_y < py && py < hi_y) hits++;
            end
            return hits;
        endfunction

        function void note_transfer(t_command c);
            int unsigned hits;
            t_winner     w;
            if (c.cmd == bwmp_pkg::CMD_POINT) begin
                if (c.first_point) n_points = 0;
                if (n_points < POINT_CAP) begin
                    xs[n_points] = c.point_x;
                    ys[n_points] = c.point_y;
                    n_points++;
                end else begin
                    dropped = 1'b1;
                end
                return;
            end
            if (run_pos < RUN_CAP) begin
                hits = count_points_inside(c);
                if (run_pos == 0 || hits > lead_count) begin
                    lead_index = run_pos;
                    lead_count = hits;
                end
                run_pos++;
            end else begin
                dropped = 1'b1;
            end
            if (c.last_box) begin
                w.best_box   = lead_index[bwmp_pkg::BOX_OUT_W-1:0];
                w.best_count = lead_count[bwmp_pkg::CNT_OUT_W-1:0];
                w.overflow   = dropped;
                winners_due  = {winners_due, w};
                run_pos    = 0;
                lead_index = 0;
                lead_count = 0;
            end
        endfunction

        function void report(string what, int unsigned want, int unsigned seen);
            failures++;
            $display("%0t: %s expected %0d actual %0d", $time, what, want, seen);
        endfunction

        function void check_winner(t_winner got);
            t_winner want;
            if (winners_due.size() == 0) begin
                failures++;
                $display("%0t: unexpected result expected none actual box %0d count %0d",
                         $time, got.best_box, got.best_count);
                return;
            end
            want = winners_due.pop_front();
            if (got.best_box !== want.best_box)
                report("best_box", 32'(want.best_box), 32'(got.best_box));
            if (got.best_count !== want.best_count)
                report("best_count", 32'(want.best_count), 32'(got.best_count));
            if (got.overflow !== want.overflow)
                report("overflow", 32'(want.overflow), 32'(got.overflow));
        endfunction

        function int unsigned pending();
            return winners_due.size();
        endfunction

        function int unsigned points_held();
            return n_points;
        endfunction

        function int unsigned run_length();
            return run_pos;
        endfunction
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           start;
    logic                           busy;
    logic                           i_cmd;
    logic                           i_first_point;
    logic [bwmp_pkg::COORD_W-1:0]   i_point_x;
    logic [bwmp_pkg::COORD_W-1:0]   i_point_y;
    logic [bwmp_pkg::EDGE_W-1:0]    i_box_left;
    logic [bwmp_pkg::EDGE_W-1:0]    i_box_top;
    logic [bwmp_pkg::EDGE_W-1:0]    i_box_width;
    logic [bwmp_pkg::EDGE_W-1:0]    i_box_height;
    logic                           i_last_box;
    logic                           o_done;
    logic [bwmp_pkg::BOX_OUT_W-1:0] o_best_box;
    logic [bwmp_pkg::CNT_OUT_W-1:0] o_best_count;
    logic                           o_overflow;

    t_box_winner_board    sb;
    int unsigned          items_sent;
    int unsigned          gap_pct;
    int unsigned          cycles;

    box_with_most_points_select_core #(
        .MAX_POINTS(POINT_CAP),
        .MAX_BOXES (RUN_CAP)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .i_first_point(i_first_point),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_box_left   (i_box_left),
        .i_box_top    (i_box_top),
        .i_box_width  (i_box_width),
        .i_box_height (i_box_height),
        .i_last_box   (i_last_box),
        .o_done       (o_done),
        .o_best_box   (o_best_box),
        .o_best_count (o_best_count),
        .o_overflow   (o_overflow)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("box_with_most_points_select_core: mismatch");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check_winner({o_best_box, o_best_count, o_overflow});
    end

    function automatic t_command point_item(logic first, logic [bwmp_pkg::COORD_W-1:0] x,
                                            logic [bwmp_pkg::COORD_W-1:0] y);
        t_command c;
        c.cmd         = bwmp_pkg::CMD_POINT;
        c.first_point = first;
        c.point_x     = x;
        c.point_y     = y;
        c.box_left    = bwmp_pkg::EDGE_W'($urandom);
        c.box_top     = bwmp_pkg::EDGE_W'($urandom);
        c.box_width   = bwmp_pkg::EDGE_W'($urandom);
        c.box_height  = bwmp_pkg::EDGE_W'($urandom);
        c.last_box    = 1'($urandom);
        return c;
    endfunction

    function automatic t_command box_item(int l, int t, int w, int h, logic last);
        t_command c;
        c.cmd         = bwmp_pkg::CMD_BOX;
        c.first_point = 1'($urandom);
        c.point_x     = bwmp_pkg::COORD_W'($urandom);
        c.point_y     = bwmp_pkg::COORD_W'($urandom);
        c.box_left    = bwmp_pkg::EDGE_W'(l);
        c.box_top     = bwmp_pkg::EDGE_W'(t);
        c.box_width   = bwmp_pkg::EDGE_W'(w);
        c.box_height  = bwmp_pkg::EDGE_W'(h);
        c.last_box    = last;
        return c;
    endfunction

    function automatic logic [bwmp_pkg::COORD_W-1:0] rand_coord();
        case ($urandom_range(9)) inside
            [0:1]:   return bwmp_pkg::COORD_W'($urandom);
            2:       return bwmp_pkg::COORD_W'($urandom_range(1250) << bwmp_pkg::FRAC_W);
            default: return bwmp_pkg::COORD_W'($urandom_range(20000));
        endcase
    endfunction

    function automatic t_command rand_box(logic last);
        case ($urandom_range(9))
            0:       return box_item($urandom, $urandom, $urandom, $urandom, last);
            1:       return box_item(0, 0, 4095, 4095, last);
            default: return box_item($urandom_range(1100), $urandom_range(1100),
                                     $urandom_range(400), $urandom_range(400), last);
        endcase
    endfunction

    task automatic send(t_command c);
        while ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        i_cmd         <= c.cmd;
        i_first_point <= c.first_point;
        i_point_x     <= c.point_x;
        i_point_y     <= c.point_y;
        i_box_left    <= c.box_left;
        i_box_top     <= c.box_top;
        i_box_width   <= c.box_width;
        i_box_height  <= c.box_height;
        i_last_box    <= c.last_box;
        start         <= 1'b1;
        do @(posedge i_clk); while (busy);
        sb.note_transfer(c);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (sb.pending() > 0) @(negedge i_clk);
    endtask

    task automatic load_points(int unsigned n);
        for (int i = 0; i < n; i++) send(point_item(i == 0, rand_coord(), rand_coord()));
    endtask

    task automatic run_boxes(int unsigned n);
        for (int i = 0; i < n; i++) send(rand_box(i == n - 1));
    endtask

    task automatic random_phase(int unsigned stop_at, bit allow_drop);
        int unsigned n;
        int unsigned room;
        t_command    c;
        logic [95:0] noise;
        while (items_sent < stop_at) begin
            case ($urandom_range(19)) inside
                [0:4]: begin
                    n = $urandom_range(1, 12);
                    if ($urandom_range(9) == 0)
                        n = $urandom_range(13, allow_drop ? POINT_CAP + 12 : POINT_CAP);
                    load_points(n);
                end
                [5:16]: begin
                    room = RUN_CAP - sb.run_length();
                    n = $urandom_range(1, 8);
                    if ($urandom_range(19) == 0) n = $urandom_range(9, RUN_CAP + 6);
                    if (!allow_drop && n > room) n = room;
                    run_boxes(n);
                end
                default: begin
                    noise = {$urandom, $urandom, $urandom};
                    c = noise[$bits(t_command)-1:0];
                    // keep early phases free of capacity drops
                    if (!allow_drop && c.cmd == bwmp_pkg::CMD_POINT &&
                        sb.points_held() >= POINT_CAP)
                        c.first_point = 1'b1;
                    if (!allow_drop && c.cmd == bwmp_pkg::CMD_BOX &&
                        sb.run_length() >= RUN_CAP - 1)
                        c.last_box = 1'b1;
                    send(c);
                end
            endcase
        end
    endtask

    initial begin
        sb            = new();
        items_sent    = 0;
        gap_pct       = 0;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_cmd         = bwmp_pkg::CMD_POINT;
        i_first_point = 1'b0;
        i_point_x     = '0;
        i_point_y     = '0;
        i_box_left    = '0;
        i_box_top     = '0;
        i_box_width   = '0;
        i_box_height  = '0;
        i_last_box    = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty point set
        send(box_item(0, 0, 4095, 4095, 1'b1));
        send(point_item(1'b1, 16'h0000, 16'h0000));
        send(point_item(1'b0, 16'hFFFF, 16'hFFFF));
        send(point_item(1'b0, 16'h0010, 16'h0010));
        send(point_item(1'b0, 16'h0011, 16'h0011));
        send(point_item(1'b0, 16'h000F, 16'h000F));
        send(point_item(1'b0, 16'h8000, 16'h8000));
        send(box_item(0, 0, 1, 1, 1'b0));
        send(box_item(1, 1, 0, 0, 1'b0));
        send(box_item(0, 0, 4095, 4095, 1'b0));
        send(box_item(4094, 4094, 4095, 4095, 1'b0));
        send(box_item(1, 1, 1, 1, 1'b0));
        send(box_item(2047, 2047, 2, 2, 1'b1));
        // equal counts keep the earlier box
        send(box_item(0, 0, 1, 1, 1'b0));
        send(box_item(1, 1, 1, 1, 1'b0));
        send(box_item(4095, 4095, 4095, 4095, 1'b1));
        send(point_item(1'b1, 16'h8000, 16'h1234));
        send(box_item(0, 0, 4095, 4095, 1'b1));
        random_phase(500, 1'b0);

        drain_results();
        gap_pct = 46;
        random_phase(1000, 1'b0);

        drain_results();
        gap_pct = 0;
        for (int i = 0; i < POINT_CAP; i++)
            send(point_item(i == 0, bwmp_pkg::COORD_W'($urandom_range(16, 65519)),
                            bwmp_pkg::COORD_W'($urandom_range(16, 65519))));
        send(box_item(0, 0, 4095, 4095, 1'b1));
        run_boxes(RUN_CAP - sb.run_length());
        random_phase(1500, 1'b0);

        drain_results();
        gap_pct = 12;
        load_points(POINT_CAP + 7);
        run_boxes(RUN_CAP + 2);
        random_phase(2000, 1'b1);

        drain_results();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (sb.failures == 0) begin
            $display("box_with_most_points_select_core: match");
        end else begin
            $display("box_with_most_points_select_core: mismatch");
        end
        $finish;
    end
endmodule
